// ----- hw/rtl/fmdd_pkg.sv -----
// Shared types and constants for the framed message deframer and dispatcher.
// Used by fmdd_ctrl, fmdd_datapath and the top level; no dependencies.
package fmdd_pkg;

  // Framing constants
  localparam logic [7:0] SYNC_BYTE = 8'h40;
  localparam int FRAME_BYTES = 5;
  localparam int ADDRESS_REGS = 4;
  localparam int SUBSCRIPTION_SLOTS = 4;
  localparam int ACTIVE_MAX = (SUBSCRIPTION_SLOTS < ADDRESS_REGS) ?
                              SUBSCRIPTION_SLOTS : ADDRESS_REGS;

  localparam int COUNT_W = $clog2(FRAME_BYTES + 1);
  localparam int SLOT_W = 2;
  localparam int REG_W = 8;
  localparam int REG_IDX_W = 3;
  localparam int IN_DATA_W = 8;
  localparam int OUT_DATA_W = 48;

  localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(FRAME_BYTES - 1);

  // Configuration register indexes
  typedef enum logic [REG_IDX_W-1:0] {
    REG_SUB_COUNT = 3'd0,
    REG_SLOT0     = 3'd1,
    REG_SLOT1     = 3'd2,
    REG_SLOT2     = 3'd3,
    REG_SLOT3     = 3'd4
  } reg_index_t;

  // Controller phases
  typedef enum logic [1:0] {
    PH_HUNT,
    PH_ONE_SYNC,
    PH_CAPTURE,
    PH_DISPATCH
  } phase_t;

  // Controller to datapath
  typedef struct packed {
    logic clear_count;
    logic take_byte;
    logic load_mask;
    logic emit;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sync_hit;
    logic count_last;
    logic match_any;
    logic mask_any;
    logic mask_last;
    logic out_free;
  } dp_status_t;

endpackage

// ----- hw/rtl/fmdd_ctrl.sv -----
// Phase controller for the deframer: sync hunt, capture and slot dispatch.
// Depends on fmdd_pkg; drives commands into fmdd_datapath.
module fmdd_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  fmdd_pkg::dp_status_t status,
  output fmdd_pkg::dp_cmd_t    cmd
);
  import fmdd_pkg::*;

  phase_t phase;
  phase_t phase_next;
  logic   take;

  assign take = in_valid && in_ready;

  // Hold the phase
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
    end else begin
      phase <= phase_next;
    end
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_HUNT: begin
        if (take && status.sync_hit) phase_next = PH_ONE_SYNC;
      end
      PH_ONE_SYNC: begin
        if (take) phase_next = status.sync_hit ? PH_CAPTURE : PH_HUNT;
      end
      PH_CAPTURE: begin
        if (take && status.count_last) begin
          phase_next = status.match_any ? PH_DISPATCH : PH_HUNT;
        end
      end
      PH_DISPATCH: begin
        if (status.out_free && status.mask_last) phase_next = PH_HUNT;
      end
      default: phase_next = PH_HUNT;
    endcase
  end

  // Commands and input handshake
  always_comb begin
    in_ready = (phase != PH_DISPATCH);
    cmd = '0;
    unique case (phase)
      PH_HUNT: ;
      PH_ONE_SYNC: begin
        cmd.clear_count = take && status.sync_hit;
      end
      PH_CAPTURE: begin
        cmd.take_byte = take;
        cmd.load_mask = take && status.count_last;
      end
      PH_DISPATCH: begin
        cmd.emit = status.out_free;
      end
      default: ;
    endcase
  end

  // Never sit in dispatch without a pending match
  a_dispatch_has_work: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DISPATCH |-> status.mask_any)
    else $error("dispatch phase with empty match mask");

  // A frame completing with a match always enters dispatch
  a_match_enters_dispatch: assert property (@(posedge clk) disable iff (rst)
    cmd.load_mask && status.match_any |=> phase == PH_DISPATCH)
    else $error("matching frame did not enter dispatch");

endmodule

// ----- hw/rtl/fmdd_datapath.sv -----
// Datapath for the deframer: configuration registers, frame capture,
// slot match mask and the result register. Depends on fmdd_pkg.
module fmdd_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic [fmdd_pkg::IN_DATA_W-1:0]         in_byte,
  input  logic                                   cfg_we,
  input  logic [fmdd_pkg::REG_IDX_W-1:0]         cfg_index,
  input  logic [fmdd_pkg::REG_W-1:0]             cfg_wdata,
  input  fmdd_pkg::dp_cmd_t                      cmd,
  output fmdd_pkg::dp_status_t                   status,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [fmdd_pkg::OUT_DATA_W-1:0]        out_data,
  output logic                                   out_last
);
  import fmdd_pkg::*;

  logic [2:0]               sub_count;
  logic [7:0]               slot_addr [ADDRESS_REGS];
  logic [COUNT_W-1:0]       payload_count;
  logic [7:0]               captured_address;
  logic [31:0]              captured_value;
  logic [ADDRESS_REGS-1:0]  mask;
  logic [ADDRESS_REGS-1:0]  match_now;
  logic [ADDRESS_REGS-1:0]  mask_rest;
  logic [2:0]               active;
  logic [SLOT_W-1:0]        sel;
  logic [SLOT_W-1:0]        out_slot;
  logic [7:0]               out_addr;
  logic [31:0]              out_value;

  // Write configuration registers; unused indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      sub_count <= '0;
      for (int i = 0; i < ADDRESS_REGS; i++) slot_addr[i] <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_SUB_COUNT: sub_count <= cfg_wdata[2:0];
        REG_SLOT0:     slot_addr[0] <= cfg_wdata;
        REG_SLOT1:     slot_addr[1] <= cfg_wdata;
        REG_SLOT2:     slot_addr[2] <= cfg_wdata;
        REG_SLOT3:     slot_addr[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Capture address and little-endian value bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_count <= '0;
      captured_address <= '0;
      captured_value <= '0;
    end else if (cmd.clear_count) begin
      payload_count <= '0;
    end else if (cmd.take_byte) begin
      if (payload_count == '0) begin
        captured_address <= in_byte;
        captured_value <= '0;
      end else begin
        captured_value[8 * (2'(payload_count - 1'b1)) +: 8] <= in_byte;
      end
      payload_count <= status.count_last ? '0 : payload_count + 1'b1;
    end
  end

  // Compare the address with each active slot
  always_comb begin
    active = (sub_count > 3'(ACTIVE_MAX)) ? 3'(ACTIVE_MAX) : sub_count;
    for (int k = 0; k < ADDRESS_REGS; k++) begin
      match_now[k] = (3'(k) < active) && (slot_addr[k] == captured_address);
    end
  end

  // Pick the lowest pending slot
  always_comb begin
    sel = '0;
    for (int k = ADDRESS_REGS - 1; k >= 0; k--) begin
      if (mask[k]) sel = SLOT_W'(k);
    end
    mask_rest = mask & ~(ADDRESS_REGS'(1) << sel);
  end

  // Hold the pending match mask
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (cmd.load_mask) begin
      mask <= match_now;
    end else if (cmd.emit) begin
      mask <= mask_rest;
    end
  end

  // Result register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_slot  <= sel;
      out_addr  <= captured_address;
      out_value <= captured_value;
      out_last  <= (mask_rest == '0);
    end
  end

  assign out_data = {6'b0, out_value, out_addr, out_slot};

  always_comb begin
    status.sync_hit   = (in_byte == SYNC_BYTE);
    status.count_last = (payload_count == COUNT_LAST);
    status.match_any  = |match_now;
    status.mask_any   = |mask;
    status.mask_last  = (mask_rest == '0);
    status.out_free   = !out_valid || out_ready;
  end

  // Results are only produced for pending matches
  a_emit_has_match: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> mask != '0)
    else $error("emit with empty match mask");

  // The final result of a frame leaves nothing pending
  a_last_clears_mask: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && status.mask_last |=> mask == '0 && out_last)
    else $error("last result left slots pending");

  // Capture counter stays inside one frame
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    payload_count <= COUNT_LAST)
    else $error("payload counter out of range");

endmodule

// ----- hw/rtl/framed_message_deframer_dispatch.sv -----
// Top level of the framed message deframer and subscription dispatcher.
// Depends on fmdd_pkg, fmdd_ctrl and fmdd_datapath.
//
// Takes one received byte per beat on s_axis, hunts for two consecutive
// '@' sync bytes, then captures an address byte and four little-endian value
// bytes. On the fifth byte the address is compared with the active
// subscription slots (count saturates at four); one result beat is sent on
// m_axis per matching slot in index order, tlast on the final one, and a
// frame with no match sends nothing. After the fifth byte is taken, a
// matching frame holds s_axis_tready low while the controller walks the
// match mask one matching slot (up to four) at a time through the
// single result register, and while m_axis_tready stalls it. Bytes of
// the next frame are accepted while a result waits to be taken. Write the
// configuration registers only while the block is idle.
module framed_message_deframer_dispatch (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [fmdd_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // [7:0] rx_byte
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [1:0] slot_index, [9:2] frame_address, [41:10] value_bits, rest zero
  output logic [fmdd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast,   // last_match
  input  logic                                cfg_we,
  input  logic [fmdd_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [fmdd_pkg::REG_W-1:0]          cfg_wdata
);
  import fmdd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  fmdd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  fmdd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (s_axis_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule
